### sv/vis_pkg.sv
// shared types and constants for the instruction step block
package vis_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);

  localparam int NUM_REGS   = 16;
  localparam int REG_ADDR_W = 4;
  localparam int REG_W      = 8;
  localparam int ADDR_W     = 12;
  localparam int WORD_W     = 16;

  localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;
  localparam logic [WORD_W-1:0] WORD_CLS = 16'h00E0;

  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    OP_CLS,
    OP_JP,
    OP_CALL,
    OP_SE_IMM,
    OP_SNE_IMM,
    OP_SE_REG,
    OP_SNE_REG,
    OP_LD,
    OP_ADD,
    OP_LDI,
    OP_BAD
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_UNSUP    = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] nnn;
  } op_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]     next_pc;
    logic [ADDR_W-1:0]     index_value;
    logic                  clear_screen;
    logic                  reg_written;
    logic [REG_ADDR_W-1:0] reg_number;
    logic [REG_W-1:0]      reg_value;
    status_t               status;
  } result_t;

endpackage

### sv/vis_instr_if.sv
// instruction channel
interface vis_instr_if;
  logic        valid;
  logic        ready;
  logic [15:0] instr_word;

  modport source(output valid, output instr_word, input ready);
  modport sink(input valid, input instr_word, output ready);
endinterface

### sv/vis_result_if.sv
// result channel
interface vis_result_if;
  logic        valid;
  logic        ready;
  logic [11:0] next_pc;
  logic [11:0] index_value;
  logic        clear_screen;
  logic        reg_written;
  logic [3:0]  reg_number;
  logic [7:0]  reg_value;
  logic [1:0]  status;

  modport source(output valid, output next_pc, output index_value, output clear_screen,
                 output reg_written, output reg_number, output reg_value, output status,
                 input ready);
  modport sink(input valid, input next_pc, input index_value, input clear_screen,
               input reg_written, input reg_number, input reg_value, input status,
               output ready);
endinterface

### sv/vis_ram.sv
// generic single write port ram with registered read
module vis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/vis_front.sv
// front part: accepts instruction words and classifies them
module vis_front (
  vis_instr_if.sink          instr,
  output logic               push_valid,
  output vis_pkg::op_item_t  push_item,
  input  logic               push_ready
);

  vis_pkg::op_t op;

  always_comb begin
    unique case (instr.instr_word[15:12])
      4'h0:    op = (instr.instr_word == vis_pkg::WORD_CLS) ? vis_pkg::OP_CLS
                                                            : vis_pkg::OP_BAD;
      4'h1:    op = vis_pkg::OP_JP;
      4'h2:    op = vis_pkg::OP_CALL;
      4'h3:    op = vis_pkg::OP_SE_IMM;
      4'h4:    op = vis_pkg::OP_SNE_IMM;
      4'h5:    op = vis_pkg::OP_SE_REG;
      4'h6:    op = vis_pkg::OP_LD;
      4'h7:    op = vis_pkg::OP_ADD;
      4'h9:    op = vis_pkg::OP_SNE_REG;
      4'hA:    op = vis_pkg::OP_LDI;
      default: op = vis_pkg::OP_BAD;
    endcase
  end

  assign push_item.op  = op;
  assign push_item.nnn = instr.instr_word[vis_pkg::ADDR_W-1:0];
  assign push_valid    = instr.valid;
  assign instr.ready   = push_ready;

endmodule

### sv/vis_queue.sv
// short queue of decoded items between front and back
module vis_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  input  vis_pkg::op_item_t  push_item,
  output logic               push_ready,
  output logic               pop_valid,
  output vis_pkg::op_item_t  pop_item,
  input  logic               pop
);

  vis_pkg::op_item_t              store [vis_pkg::QUEUE_DEPTH];
  logic [vis_pkg::Q_PTR_W-1:0]    wr_ptr;
  logic [vis_pkg::Q_PTR_W-1:0]    rd_ptr;
  logic [vis_pkg::Q_CNT_W-1:0]    count;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready = !rst && (count != vis_pkg::Q_CNT_W'(vis_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = store[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == vis_pkg::Q_PTR_W'(vis_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == vis_pkg::Q_PTR_W'(vis_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/vis_back.sv
// back part: register reads, execution against machine state, result register
module vis_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  input  vis_pkg::op_item_t  pop_item,
  output logic               pop,
  vis_result_if.source       result
);

  // execute stage
  logic                              ex_valid;
  vis_pkg::op_item_t                 ex_item;
  logic                              byp_valid;
  logic [vis_pkg::REG_ADDR_W-1:0]    byp_num;
  logic [vis_pkg::REG_W-1:0]         byp_val;

  // machine state
  logic [vis_pkg::ADDR_W-1:0]        pc;
  logic [vis_pkg::ADDR_W-1:0]        index_reg;
  logic [vis_pkg::SP_W-1:0]          stack_ptr;
  logic [vis_pkg::NUM_REGS-1:0]      reg_valid;

  // output register
  logic                              out_valid;
  vis_pkg::result_t                  out_res;

  logic                              exec_fire;
  logic                              load_ex;
  logic [vis_pkg::REG_W-1:0]         ram_x;
  logic [vis_pkg::REG_W-1:0]         ram_y;
  logic [vis_pkg::REG_ADDR_W-1:0]    x;
  logic [vis_pkg::REG_ADDR_W-1:0]    y;
  logic [vis_pkg::REG_W-1:0]         nn;
  logic [vis_pkg::REG_W-1:0]         vx;
  logic [vis_pkg::REG_W-1:0]         vy;
  logic [vis_pkg::ADDR_W-1:0]        pc_plus2;
  logic [vis_pkg::ADDR_W-1:0]        pc_plus4;
  logic [vis_pkg::ADDR_W-1:0]        pc_next;
  logic [vis_pkg::ADDR_W-1:0]        index_next;
  logic [vis_pkg::SP_W-1:0]          stack_ptr_next;
  vis_pkg::result_t                  res;

  assign exec_fire = ex_valid && (!out_valid || result.ready);
  assign load_ex   = pop_valid && (!ex_valid || exec_fire);
  assign pop       = load_ex;

  vis_ram #(.WIDTH(vis_pkg::REG_W), .DEPTH(vis_pkg::NUM_REGS)) u_regs_x (
    .clk   (clk),
    .we    (exec_fire && res.reg_written),
    .waddr (res.reg_number),
    .wdata (res.reg_value),
    .re    (load_ex),
    .raddr (pop_item.nnn[11:8]),
    .rdata (ram_x)
  );

  vis_ram #(.WIDTH(vis_pkg::REG_W), .DEPTH(vis_pkg::NUM_REGS)) u_regs_y (
    .clk   (clk),
    .we    (exec_fire && res.reg_written),
    .waddr (res.reg_number),
    .wdata (res.reg_value),
    .re    (load_ex),
    .raddr (pop_item.nnn[7:4]),
    .rdata (ram_y)
  );

  assign x  = ex_item.nnn[11:8];
  assign y  = ex_item.nnn[7:4];
  assign nn = ex_item.nnn[7:0];

  // write landing on the same edge as the read is taken from the bypass
  always_comb begin
    if (byp_valid && byp_num == x) begin
      vx = byp_val;
    end else if (reg_valid[x]) begin
      vx = ram_x;
    end else begin
      vx = '0;
    end
    if (byp_valid && byp_num == y) begin
      vy = byp_val;
    end else if (reg_valid[y]) begin
      vy = ram_y;
    end else begin
      vy = '0;
    end
  end

  assign pc_plus2 = pc + vis_pkg::ADDR_W'(2);
  assign pc_plus4 = pc + vis_pkg::ADDR_W'(4);

  always_comb begin
    pc_next          = pc;
    index_next       = index_reg;
    stack_ptr_next   = stack_ptr;
    res.clear_screen = 1'b0;
    res.reg_written  = 1'b0;
    res.reg_number   = '0;
    res.reg_value    = '0;
    res.status       = vis_pkg::STAT_OK;
    unique case (ex_item.op)
      vis_pkg::OP_CLS: begin
        res.clear_screen = 1'b1;
        pc_next          = pc_plus2;
      end
      vis_pkg::OP_JP: begin
        pc_next = ex_item.nnn;
      end
      vis_pkg::OP_CALL: begin
        if (stack_ptr == vis_pkg::SP_W'(vis_pkg::STACK_DEPTH)) begin
          res.status = vis_pkg::STAT_OVERFLOW;
        end else begin
          stack_ptr_next = stack_ptr + 1'b1;
          pc_next        = ex_item.nnn;
        end
      end
      vis_pkg::OP_SE_IMM:  pc_next = (vx == nn) ? pc_plus4 : pc_plus2;
      vis_pkg::OP_SNE_IMM: pc_next = (vx != nn) ? pc_plus4 : pc_plus2;
      vis_pkg::OP_SE_REG:  pc_next = (vx == vy) ? pc_plus4 : pc_plus2;
      vis_pkg::OP_SNE_REG: pc_next = (vx != vy) ? pc_plus4 : pc_plus2;
      vis_pkg::OP_LD: begin
        res.reg_written = 1'b1;
        res.reg_number  = x;
        res.reg_value   = nn;
        pc_next         = pc_plus2;
      end
      vis_pkg::OP_ADD: begin
        res.reg_written = 1'b1;
        res.reg_number  = x;
        res.reg_value   = vx + nn;
        pc_next         = pc_plus2;
      end
      vis_pkg::OP_LDI: begin
        index_next = ex_item.nnn;
        pc_next    = pc_plus2;
      end
      default: begin
        res.status = vis_pkg::STAT_UNSUP;
      end
    endcase
    res.next_pc     = pc_next;
    res.index_value = index_next;
  end

  always_ff @(posedge clk) begin
    if (load_ex) begin
      ex_item <= pop_item;
      byp_num <= res.reg_number;
      byp_val <= res.reg_value;
    end
    if (exec_fire) begin
      out_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid  <= 1'b0;
      byp_valid <= 1'b0;
      out_valid <= 1'b0;
      pc        <= vis_pkg::PC_RESET;
      index_reg <= '0;
      stack_ptr <= '0;
      reg_valid <= '0;
    end else begin
      if (load_ex) begin
        ex_valid  <= 1'b1;
        byp_valid <= exec_fire && res.reg_written;
      end else if (exec_fire) begin
        ex_valid <= 1'b0;
      end
      if (exec_fire) begin
        out_valid <= 1'b1;
        pc        <= pc_next;
        index_reg <= index_next;
        stack_ptr <= stack_ptr_next;
        if (res.reg_written) begin
          reg_valid[res.reg_number] <= 1'b1;
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.next_pc      = out_res.next_pc;
  assign result.index_value  = out_res.index_value;
  assign result.clear_screen = out_res.clear_screen;
  assign result.reg_written  = out_res.reg_written;
  assign result.reg_number   = out_res.reg_number;
  assign result.reg_value    = out_res.reg_value;
  assign result.status       = out_res.status;

endmodule

### sv/vm_instruction_step_top.sv
// top level of the instruction step block
//
// the instr channel takes one 16-bit instruction word per item, fetched at
// the current program counter. the result channel returns one item per
// instruction: next pc, index register, clear-screen flag, register write
// (flag, number, value) and a status code (ok, unsupported, stack overflow).
// a decoder feeds a two-entry queue; the back end reads the general
// registers from two small rams, executes, and holds the result in an
// output register. a register write landing on the same edge as the next
// read is bypassed.
// throughput is one instruction per cycle while results are taken, set
// by the execute stage that updates pc, index and stack pointer. an
// instruction passes the queue and execute stage to the output register.
// reset (rst, synchronous) sets pc to 0x200, clears index, stack pointer,
// general registers and the queue; items are taken from the next cycle.
// when the receiver stalls, the output register holds its item, the
// execute stage and the queue fill, and instr.ready drops once the queue
// is full.
module vm_instruction_step_top (
  input  logic          clk,
  input  logic          rst,
  vis_instr_if.sink     instr,
  vis_result_if.source  result
);

  logic               push_valid;
  logic               push_ready;
  vis_pkg::op_item_t  push_item;
  logic               pop_valid;
  logic               pop;
  vis_pkg::op_item_t  pop_item;

  vis_front u_front (
    .instr      (instr),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  vis_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop        (pop)
  );

  vis_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .result    (result)
  );

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the instruction step block
import vis_pkg::*;

localparam logic [3:0] GRP_SYS     = 4'h0;
localparam logic [3:0] GRP_JP      = 4'h1;
localparam logic [3:0] GRP_CALL    = 4'h2;
localparam logic [3:0] GRP_SE_IMM  = 4'h3;
localparam logic [3:0] GRP_SNE_IMM = 4'h4;
localparam logic [3:0] GRP_SE_REG  = 4'h5;
localparam logic [3:0] GRP_LD      = 4'h6;
localparam logic [3:0] GRP_ADD     = 4'h7;
localparam logic [3:0] GRP_ALU     = 4'h8;
localparam logic [3:0] GRP_SNE_REG = 4'h9;
localparam logic [3:0] GRP_LDI     = 4'hA;
localparam logic [3:0] GRP_JPV0    = 4'hB;

class step_scoreboard;
  logic [ADDR_W-1:0] pc;
  logic [ADDR_W-1:0] index_reg;
  logic [REG_W-1:0]  vregs [NUM_REGS];
  int                depth;
  result_t           pending_results [$];
  int                errors;

  function new();
    pc = PC_RESET;
    index_reg = '0;
    foreach (vregs[i]) vregs[i] = '0;
    depth = 0;
    errors = 0;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function void note_instr(logic [WORD_W-1:0] w);
    logic [3:0]        grp;
    logic [3:0]        x;
    logic [3:0]        y;
    logic [7:0]        nn;
    logic [ADDR_W-1:0] nnn;
    result_t           r;
    grp = w[15:12];
    x = w[11:8];
    y = w[7:4];
    nn = w[7:0];
    nnn = w[11:0];
    r = '0;
    r.status = STAT_OK;
    case (grp)
      GRP_SYS: begin
        if (w == WORD_CLS) begin
          r.clear_screen = 1'b1;
          pc = pc + 12'd2;
        end else begin
          r.status = STAT_UNSUP;
        end
      end
      GRP_JP: pc = nnn;
      GRP_CALL: begin
        if (depth >= STACK_DEPTH) begin
          r.status = STAT_OVERFLOW;
        end else begin
          depth++;
          pc = nnn;
        end
      end
      GRP_SE_IMM:  pc = pc + ((vregs[x] == nn) ? 12'd4 : 12'd2);
      GRP_SNE_IMM: pc = pc + ((vregs[x] != nn) ? 12'd4 : 12'd2);
      GRP_SE_REG:  pc = pc + ((vregs[x] == vregs[y]) ? 12'd4 : 12'd2);
      GRP_SNE_REG: pc = pc + ((vregs[x] != vregs[y]) ? 12'd4 : 12'd2);
      GRP_LD, GRP_ADD: begin
        vregs[x] = (grp == GRP_LD) ? nn : vregs[x] + nn;
        r.reg_written = 1'b1;
        r.reg_number = x;
        r.reg_value = vregs[x];
        pc = pc + 12'd2;
      end
      GRP_LDI: begin
        index_reg = nnn;
        pc = pc + 12'd2;
      end
      default: r.status = STAT_UNSUP;
    endcase
    r.next_pc = pc;
    r.index_value = index_reg;
    pending_results.push_back(r);
  endfunction

  function void cmp(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result item with none expected, actual %0h", $time, got);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    cmp("next_pc", want.next_pc, got.next_pc);
    cmp("index_value", want.index_value, got.index_value);
    cmp("clear_screen", want.clear_screen, got.clear_screen);
    cmp("reg_written", want.reg_written, got.reg_written);
    cmp("reg_number", want.reg_number, got.reg_number);
    cmp("reg_value", want.reg_value, got.reg_value);
    cmp("status", want.status, got.status);
  endfunction
endclass

module tb_top;
  localparam int RANDOM_ITEMS = 575;
  localparam int IDLE_LIMIT   = 2000;

  logic clk = 1'b0;
  logic rst;
  step_scoreboard sb = new();

  vis_instr_if  instr_ch();
  vis_result_if result_ch();

  vm_instruction_step_top dut (
    .clk(clk),
    .rst(rst),
    .instr(instr_ch),
    .result(result_ch)
  );

  always #6 clk = ~clk;

  task automatic send_word(logic [WORD_W-1:0] w, bit gaps);
    while (gaps && $urandom_range(99) < 12) begin
      instr_ch.valid <= 1'b0;
      @(posedge clk);
    end
    instr_ch.valid <= 1'b1;
    instr_ch.instr_word <= w;
    do @(posedge clk); while (!instr_ch.ready);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    int unsigned       sel;
    logic [3:0]        x;
    logic [3:0]        y;
    logic [7:0]        nn;
    logic [ADDR_W-1:0] nnn;
    sel = $urandom_range(99);
    x = 4'($urandom_range(15));
    y = 4'($urandom_range(15));
    case ($urandom_range(3))
      0: nn = 8'h00;
      1: nn = 8'hFF;
      2: nn = 8'h01;
      default: nn = 8'($urandom);
    endcase
    case ($urandom_range(3))
      0: nnn = 12'hFFE;
      1: nnn = 12'hFFC;
      default: nnn = 12'($urandom);
    endcase
    if (sel < 8) return 16'($urandom);
    if (sel < 10) return {GRP_ALU, 12'($urandom)};
    if (sel < 12) return {GRP_JPV0 + 4'($urandom_range(4)), 12'($urandom)};
    if (sel < 15) return {GRP_SYS, 12'($urandom)};
    if (sel < 19) return {GRP_CALL, nnn};
    case ($urandom_range(9))
      0: return WORD_CLS;
      1: return {GRP_JP, nnn};
      2: return {GRP_SE_IMM, x, nn};
      3: return {GRP_SNE_IMM, x, nn};
      4: return {GRP_SE_REG, x, y, 4'($urandom)};
      5: return {GRP_SNE_REG, x, y, 4'($urandom)};
      6: return {GRP_ADD, x, nn};
      7: return {GRP_LDI, 12'($urandom)};
      default: return {GRP_LD, x, nn};
    endcase
  endfunction

  always @(posedge clk) begin
    result_t got;
    if (!rst) begin
      if (instr_ch.valid && instr_ch.ready) sb.note_instr(instr_ch.instr_word);
      if (result_ch.valid && result_ch.ready) begin
        got.next_pc = result_ch.next_pc;
        got.index_value = result_ch.index_value;
        got.clear_screen = result_ch.clear_screen;
        got.reg_written = result_ch.reg_written;
        got.reg_number = result_ch.reg_number;
        got.reg_value = result_ch.reg_value;
        got.status = status_t'(result_ch.status);
        sb.check_result(got);
      end
    end
  end

  // receiver: random stalls, a quiet stretch and one long hold-off
  initial begin
    int cyc;
    cyc = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 300) begin
        result_ch.ready <= 1'b0;
        repeat (60) @(posedge clk);
      end
      result_ch.ready <= (cyc >= 120 && cyc < 260) || ($urandom_range(99) >= 12);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [WORD_W-1:0] directed [$];
    directed = '{
      WORD_CLS, 16'h0000, 16'h0FFF, WORD_CLS + 16'h1,
      {GRP_LD, 4'h0, 8'h00}, {GRP_LD, 4'hF, 8'hFF}, {GRP_ADD, 4'hF, 8'hFF},
      {GRP_ADD, 4'h0, 8'h01}, {GRP_SE_IMM, 4'h0, 8'h01}, {GRP_SE_IMM, 4'hF, 8'h00},
      {GRP_SNE_IMM, 4'hF, 8'h00}, {GRP_SNE_IMM, 4'h0, 8'h01},
      {GRP_SE_REG, 4'h0, 4'h1, 4'h0}, {GRP_SE_REG, 4'h1, 4'h2, 4'hF},
      {GRP_SNE_REG, 4'h0, 4'h1, 4'h0}, {GRP_SNE_REG, 4'h1, 4'h2, 4'hF},
      {GRP_LDI, 12'h000}, {GRP_LDI, 12'hFFF},
      {GRP_JP, 12'hFFE}, WORD_CLS, {GRP_JP, 12'hFFC}, {GRP_SE_IMM, 4'h1, 8'h00},
      {GRP_CALL, 12'hABC}, {GRP_ALU, 12'h123}, 16'hFFFF
    };
    rst <= 1'b1;
    instr_ch.valid <= 1'b0;
    instr_ch.instr_word <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_word(directed[i], 1'b1);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 400) begin
        instr_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      send_word(pick_word(), !(i >= 100 && i < 250));
    end
    instr_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
